### rtl/bef_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Button event frame builder package
// Shared command codes, button signal codes, ring control types and the
// saturating disk activity scaling function.
// ----------------------------------------------------------------------------
package bef_pkg;

	// Command codes carried in the mode field. Codes 0..3 double as ring
	// event codes.
	localparam logic [2:0] MODE_PWR_PRESS = 3'd0;
	localparam logic [2:0] MODE_PWR_REL   = 3'd1;
	localparam logic [2:0] MODE_RST_PRESS = 3'd2;
	localparam logic [2:0] MODE_RST_REL   = 3'd3;
	localparam logic [2:0] MODE_ADD_EDGES = 3'd4;
	localparam logic [2:0] MODE_FRAME     = 3'd5;
	localparam logic [2:0] MODE_CLEAR     = 3'd6;

	// Event codes as stored in the ring.
	localparam logic [1:0] EV_PWR_PRESS = 2'd0;
	localparam logic [1:0] EV_PWR_REL   = 2'd1;
	localparam logic [1:0] EV_RST_PRESS = 2'd2;
	localparam logic [1:0] EV_RST_REL   = 2'd3;

	// Button signal codes in a frame.
	localparam logic [1:0] BTN_LOW  = 2'd0;
	localparam logic [1:0] BTN_HIGH = 2'd1;
	localparam logic [1:0] BTN_RISE = 2'd2;
	localparam logic [1:0] BTN_FALL = 2'd3;

	// Configuration register indexes.
	localparam logic REG_STRIP_POWER = 1'b0;
	localparam logic REG_EDGE_BOOST  = 1'b1;

	localparam logic [7:0]  EDGE_MAX    = 8'hFF;
	localparam logic [14:0] CONTRIB_MAX = 15'h7FFF;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clr;
		logic [1:0] code;
	} ring_ctl_t;

	typedef struct packed {
		logic       empty;
		logic [1:0] head_code;
	} ring_sts_t;

	// edges * boost * 256, saturated to 15 bits. The product stays below
	// the limit only while edges * boost is below 128.
	function automatic logic [14:0] scale_contrib(input logic [7:0] edges,
			input logic [7:0] boost);
		logic [15:0] prod;
		prod = 16'(edges) * 16'(boost);
		if (prod[15:7] != 9'd0) begin
			scale_contrib = CONTRIB_MAX;
		end else begin
			scale_contrib = {prod[6:0], 8'h00};
		end
	endfunction

endpackage
`default_nettype wire

### rtl/button_event_frame_builder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Button event frame builder
// Command stream in, one status or frame result out for every command.
// ----------------------------------------------------------------------------
// Every accepted command yields exactly one result. Power and reset presses or
// releases that change the requested button level are queued in an event ring
// of QUEUE_DEPTH entries; when the ring is full the event is dropped while the
// requested level still follows. Disk edge counts accumulate, saturating at
// 255. A frame command reports the sampled LED levels, the strip power flag,
// and the disk contribution min(32767, edges * boost * 256); it also clears
// the edge count and dequeues at most one button event, which shows as rising
// or falling while the other button shows its delivered level. The clear
// command resets the ring pointers, the edge count and all button levels.
// The block takes one command per clock cycle while the result side is ready,
// and passes it through the input register, where all the work is done by
// short logic against the current state, and then the result register.
// Configuration writes are always ready and take effect at once; they are
// meant to happen while no command is in flight.
module button_event_frame_builder_unit #(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire        clk,
	input  wire        arst_n,
	// Command channel
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	// tdata: [7:0] edge_count, [8] power_led_in, [9] hdd_led_in, [15:10] zero
	input  wire [15:0] s_axis_tdata,
	// tuser: [2:0] mode
	input  wire [2:0]  s_axis_tuser,
	// Result channel
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	// tdata: [1:0] power_button_state, [3:2] reset_button_state,
	//        [4] power_led_out, [5] hdd_led_out, [20:6] hdd_contribution,
	//        [21] strip_power_out, [29:22] pending_edges, [31:30] zero
	output logic [31:0] m_axis_tdata,
	// tuser: [0] frame_valid
	output logic       m_axis_tuser,
	// Configuration write channel
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire        cfg_index,
	input  wire [7:0]  cfg_data
);
	import bef_pkg::*;

	// Configuration registers.
	logic       strip_power_q;
	logic [7:0] edge_boost_q;

	// Input register.
	logic       valid_s1;
	logic [2:0] mode_s1;
	logic [7:0] count_s1;
	logic       pled_s1;
	logic       hled_s1;

	// Persistent state.
	logic [7:0] acc_q;
	logic       pwr_req_q;
	logic       rst_req_q;
	logic       pwr_del_q;
	logic       rst_del_q;

	// Result register.
	logic        out_valid_q;
	logic        frame_q;
	logic [1:0]  pbs_q;
	logic [1:0]  rbs_q;
	logic        pled_q;
	logic        hled_q;
	logic [14:0] contrib_q;
	logic        strip_q;
	logic [7:0]  pend_q;

	logic        advance;
	ring_ctl_t   ring_ctl;
	ring_sts_t   ring_sts;

	// Next-state and result values for the command in the input register.
	logic [8:0]  edge_sum;
	logic [7:0]  edge_sat;
	logic [7:0]  acc_nx;
	logic        pwr_req_nx;
	logic        rst_req_nx;
	logic        pwr_del_nx;
	logic        rst_del_nx;
	logic        frame_nx;
	logic [1:0]  pbs_nx;
	logic [1:0]  rbs_nx;
	logic [14:0] contrib_nx;
	logic        pop_evt;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_power_q <= 1'b0;
			edge_boost_q  <= 8'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_STRIP_POWER: strip_power_q <= cfg_data[0];
				REG_EDGE_BOOST:  edge_boost_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input register moves on whenever the result register is free or
	// being emptied in the same cycle.
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			mode_s1  <= s_axis_tuser;
			count_s1 <= s_axis_tdata[7:0];
			pled_s1  <= s_axis_tdata[8];
			hled_s1  <= s_axis_tdata[9];
		end
	end

	assign edge_sum = {1'b0, acc_q} + {1'b0, count_s1};
	assign edge_sat = edge_sum[8] ? EDGE_MAX : edge_sum[7:0];
	assign pop_evt  = (mode_s1 == MODE_FRAME) && !ring_sts.empty;

	always_comb begin
		acc_nx       = acc_q;
		pwr_req_nx   = pwr_req_q;
		rst_req_nx   = rst_req_q;
		pwr_del_nx   = pwr_del_q;
		rst_del_nx   = rst_del_q;
		frame_nx     = 1'b0;
		pbs_nx       = BTN_LOW;
		rbs_nx       = BTN_LOW;
		contrib_nx   = '0;
		ring_ctl.push = 1'b0;
		ring_ctl.pop  = 1'b0;
		ring_ctl.clr  = 1'b0;
		ring_ctl.code = mode_s1[1:0];
		case (mode_s1)
			MODE_PWR_PRESS: begin
				pwr_req_nx    = 1'b1;
				ring_ctl.push = !pwr_req_q;
			end
			MODE_PWR_REL: begin
				pwr_req_nx    = 1'b0;
				ring_ctl.push = pwr_req_q;
			end
			MODE_RST_PRESS: begin
				rst_req_nx    = 1'b1;
				ring_ctl.push = !rst_req_q;
			end
			MODE_RST_REL: begin
				rst_req_nx    = 1'b0;
				ring_ctl.push = rst_req_q;
			end
			MODE_ADD_EDGES: begin
				acc_nx = edge_sat;
			end
			MODE_FRAME: begin
				acc_nx       = '0;
				frame_nx     = 1'b1;
				contrib_nx   = scale_contrib(edge_sat, edge_boost_q);
				ring_ctl.pop = 1'b1;
				if (pop_evt) begin
					case (ring_sts.head_code)
						EV_PWR_PRESS: pwr_del_nx = 1'b1;
						EV_PWR_REL:   pwr_del_nx = 1'b0;
						EV_RST_PRESS: rst_del_nx = 1'b1;
						default:      rst_del_nx = 1'b0;
					endcase
				end
				// A button that just changed shows its edge; otherwise its level.
				if (pop_evt && (ring_sts.head_code == EV_PWR_PRESS)) begin
					pbs_nx = BTN_RISE;
				end else if (pop_evt && (ring_sts.head_code == EV_PWR_REL)) begin
					pbs_nx = BTN_FALL;
				end else begin
					pbs_nx = pwr_del_q ? BTN_HIGH : BTN_LOW;
				end
				if (pop_evt && (ring_sts.head_code == EV_RST_PRESS)) begin
					rbs_nx = BTN_RISE;
				end else if (pop_evt && (ring_sts.head_code == EV_RST_REL)) begin
					rbs_nx = BTN_FALL;
				end else begin
					rbs_nx = rst_del_q ? BTN_HIGH : BTN_LOW;
				end
			end
			MODE_CLEAR: begin
				acc_nx       = '0;
				pwr_req_nx   = 1'b0;
				rst_req_nx   = 1'b0;
				pwr_del_nx   = 1'b0;
				rst_del_nx   = 1'b0;
				ring_ctl.clr = 1'b1;
			end
			default: ;
		endcase
		// The ring only acts when the command actually leaves the input register.
		if (!advance) begin
			ring_ctl.push = 1'b0;
			ring_ctl.pop  = 1'b0;
			ring_ctl.clr  = 1'b0;
		end
	end

	bef_ring #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.sts    (ring_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			pwr_req_q <= 1'b0;
			rst_req_q <= 1'b0;
			pwr_del_q <= 1'b0;
			rst_del_q <= 1'b0;
		end else if (advance) begin
			acc_q     <= acc_nx;
			pwr_req_q <= pwr_req_nx;
			rst_req_q <= rst_req_nx;
			pwr_del_q <= pwr_del_nx;
			rst_del_q <= rst_del_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Non-frame results carry only the pending edge count; the rest is zero.
	always_ff @(posedge clk) begin
		if (advance) begin
			frame_q   <= frame_nx;
			pbs_q     <= pbs_nx;
			rbs_q     <= rbs_nx;
			pled_q    <= frame_nx & pled_s1;
			hled_q    <= frame_nx & hled_s1;
			contrib_q <= contrib_nx;
			strip_q   <= frame_nx & strip_power_q;
			pend_q    <= acc_nx;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = frame_q;
	assign m_axis_tdata  = {2'b00, pend_q, strip_q, contrib_q, hled_q, pled_q,
		rbs_q, pbs_q};

endmodule
`default_nettype wire

### rtl/bef_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Button event ring
// Small circular queue of button events with a registered head read that is
// always ready for the next dequeue.
// ----------------------------------------------------------------------------
module bef_ring #(
	parameter int QUEUE_DEPTH = 8
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire bef_pkg::ring_ctl_t ctl,
	output bef_pkg::ring_sts_t sts
);
	import bef_pkg::*;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	logic [1:0]       mem [QUEUE_DEPTH];
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [1:0]       head_code_q;
	logic [IDX_W-1:0] head_nx;
	logic             full;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign do_push = ctl.push && !full;
	assign do_pop  = ctl.pop && (count_q != '0);

	always_comb begin
		if (ctl.clr) begin
			head_nx = '0;
		end else if (do_pop) begin
			head_nx = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
		end else begin
			head_nx = head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (ctl.clr) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			head_q <= head_nx;
			if (do_push) begin
				tail_q  <= (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end else if (do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push && !ctl.clr) begin
			mem[tail_q] <= ctl.code;
		end
	end

	// The head entry is read ahead into a register from the next head pointer; a
	// push into an empty ring is forwarded so that the very next frame sees it.
	always_ff @(posedge clk) begin
		if (do_push && !ctl.clr && (tail_q == head_nx)) begin
			head_code_q <= ctl.code;
		end else begin
			head_code_q <= mem[head_nx];
		end
	end

	assign sts.empty     = (count_q == '0);
	assign sts.head_code = head_code_q;

endmodule
`default_nettype wire

### bench/button_event_frame_builder_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button event frame builder unit test
// Drives command requests into the frame builder and checks every result
// request against an in-bench prediction of the button ring, the edge
// accumulator and the frame fields, under random idling and backpressure.
// ----------------------------------------------------------------------------
module button_event_frame_builder_unit_test;
	import bef_pkg::*;

	localparam int RING_DEPTH = 8;
	// Mode 7 has no meaning: it must leave all state alone.
	localparam logic [2:0] MODE_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 200000;
	// Extra wait once every awaited result has come back.
	localparam int SETTLE_CYCLES = 4;

	typedef struct packed {
		logic        frame;
		logic [1:0]  pwr_btn;
		logic [1:0]  rst_btn;
		logic        pwr_led;
		logic        hdd_led;
		logic [14:0] contrib;
		logic        strip;
		logic [7:0]  pending;
	} frame_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;

	button_event_frame_builder_unit #(
		.QUEUE_DEPTH(RING_DEPTH)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Predicted state of the block, updated at every accepted command.
	logic [1:0] ring_codes [RING_DEPTH];
	logic [2:0] ring_rd_ptr;
	logic [3:0] ring_fill;
	logic [7:0] edge_total;
	logic       power_req_lvl;
	logic       reset_req_lvl;
	logic       power_dlv_lvl;
	logic       reset_dlv_lvl;
	logic       strip_power_cfg;
	logic [7:0] edge_boost_cfg;

	// Results still owed by the block, oldest first.
	frame_result_t awaited_results [$];

	int mismatch_count = 0;
	int cycle_count = 0;
	// Random idling switches for the command side and the result side.
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	// A nonzero value asks the result side to hold off; the value sets how long.
	int rx_hold_request = 0;

	logic [2:0] button_modes [4] = '{MODE_PWR_PRESS, MODE_PWR_REL, MODE_RST_PRESS,
		MODE_RST_REL};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a run that hangs or loses results ends here.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL button_event_frame_builder_unit");
		$finish;
	end

	function automatic void clear_transient_state();
		ring_rd_ptr = '0;
		ring_fill = '0;
		edge_total = '0;
		power_req_lvl = 1'b0;
		reset_req_lvl = 1'b0;
		power_dlv_lvl = 1'b0;
		reset_dlv_lvl = 1'b0;
	endfunction

	// A full ring drops the event; the requested level has already moved.
	function automatic void queue_button_event(input logic [1:0] code);
		logic [2:0] slot;
		if (ring_fill < RING_DEPTH) begin
			slot = ring_rd_ptr + ring_fill[2:0];
			ring_codes[slot] = code;
			ring_fill++;
		end
	endfunction

	// Works out the result of one command and advances the predicted state.
	function automatic frame_result_t predict_frame_result(input logic [2:0] mode,
			input logic [7:0] count, input logic pled, input logic hled);
		frame_result_t res;
		logic [8:0]    sum;
		logic [7:0]    edges;
		logic [31:0]   product;
		logic [1:0]    code;
		res = '0;
		sum = {1'b0, edge_total} + {1'b0, count};
		edges = sum[8] ? EDGE_MAX : sum[7:0];
		case (mode)
			MODE_PWR_PRESS: begin
				if (!power_req_lvl) begin
					power_req_lvl = 1'b1;
					queue_button_event(EV_PWR_PRESS);
				end
			end
			MODE_PWR_REL: begin
				if (power_req_lvl) begin
					power_req_lvl = 1'b0;
					queue_button_event(EV_PWR_REL);
				end
			end
			MODE_RST_PRESS: begin
				if (!reset_req_lvl) begin
					reset_req_lvl = 1'b1;
					queue_button_event(EV_RST_PRESS);
				end
			end
			MODE_RST_REL: begin
				if (reset_req_lvl) begin
					reset_req_lvl = 1'b0;
					queue_button_event(EV_RST_REL);
				end
			end
			MODE_ADD_EDGES: begin
				edge_total = edges;
			end
			MODE_FRAME: begin
				edge_total = '0;
				product = 32'(edges) * 32'(edge_boost_cfg) * 32'd256;
				res.contrib = (product > 32'(CONTRIB_MAX)) ? CONTRIB_MAX : product[14:0];
				res.pwr_btn = BTN_LOW;
				res.rst_btn = BTN_LOW;
				// At most one queued event is delivered per frame.
				if (ring_fill != 0) begin
					code = ring_codes[ring_rd_ptr];
					ring_rd_ptr++;
					ring_fill--;
					case (code)
						EV_PWR_PRESS: begin
							power_dlv_lvl = 1'b1;
							res.pwr_btn = BTN_RISE;
						end
						EV_PWR_REL: begin
							power_dlv_lvl = 1'b0;
							res.pwr_btn = BTN_FALL;
						end
						EV_RST_PRESS: begin
							reset_dlv_lvl = 1'b1;
							res.rst_btn = BTN_RISE;
						end
						default: begin
							reset_dlv_lvl = 1'b0;
							res.rst_btn = BTN_FALL;
						end
					endcase
				end
				if (res.pwr_btn == BTN_LOW && power_dlv_lvl) begin
					res.pwr_btn = BTN_HIGH;
				end
				if (res.rst_btn == BTN_LOW && reset_dlv_lvl) begin
					res.rst_btn = BTN_HIGH;
				end
				res.frame = 1'b1;
				res.pwr_led = pled;
				res.hdd_led = hled;
				res.strip = strip_power_cfg;
			end
			MODE_CLEAR: begin
				clear_transient_state();
			end
			default: begin
			end
		endcase
		res.pending = edge_total;
		return res;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// Result side: every accepted result is matched against the oldest
	// expectation, field by field.
	always @(posedge clk) begin : check_results
		frame_result_t seen;
		frame_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen.frame = m_axis_tuser;
			seen.pwr_btn = m_axis_tdata[1:0];
			seen.rst_btn = m_axis_tdata[3:2];
			seen.pwr_led = m_axis_tdata[4];
			seen.hdd_led = m_axis_tdata[5];
			seen.contrib = m_axis_tdata[20:6];
			seen.strip = m_axis_tdata[21];
			seen.pending = m_axis_tdata[29:22];
			if (awaited_results.size() == 0) begin
				$error("result request with no command outstanding: tdata %h tuser %b",
					m_axis_tdata, m_axis_tuser);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				check_field("frame_valid", want.frame, seen.frame);
				check_field("power_button_state", want.pwr_btn, seen.pwr_btn);
				check_field("reset_button_state", want.rst_btn, seen.rst_btn);
				check_field("power_led_out", want.pwr_led, seen.pwr_led);
				check_field("hdd_led_out", want.hdd_led, seen.hdd_led);
				check_field("hdd_contribution", want.contrib, seen.contrib);
				check_field("strip_power_out", want.strip, seen.strip);
				check_field("pending_edges", want.pending, seen.pending);
			end
		end
	end

	// Result side ready: random stall bursts, plus the long hold-off that a
	// test can ask for. The hold-off is counted here, in cycles.
	initial begin : drive_result_ready
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_request != 0) begin
				stall_left = rx_hold_request;
				rx_hold_request = 0;
			end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 11);
			end
			if (stall_left != 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	// Offers one command and returns once it has been accepted. tvalid stays
	// high afterwards so back-to-back commands follow without a gap.
	task automatic send_command(input logic [2:0] mode, input logic [7:0] count,
			input logic pled, input logic hled);
		int gap;
		gap = 0;
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
		end
		@(negedge clk);
		if (gap != 0) begin
			// While idle, the data lines carry junk that must be ignored.
			s_axis_tvalid = 1'b0;
			s_axis_tdata = 16'($urandom);
			s_axis_tuser = 3'($urandom);
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {6'd0, hled, pled, count};
		s_axis_tuser = mode;
		do @(posedge clk); while (!s_axis_tready);
		awaited_results.push_back(predict_frame_result(mode, count, pled, hled));
	endtask

	// Stops offering commands and waits until every result has come back.
	task automatic wait_for_results();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic index, input logic [7:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		if (index == REG_STRIP_POWER) begin
			strip_power_cfg = value[0];
		end else begin
			edge_boost_cfg = value;
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Mostly well-formed traffic: button toggles, edge additions and frames,
	// with a little clear and unused-mode noise. frame_pct sets how often
	// frames drain the ring, and so how often the ring runs full.
	task automatic send_random_commands(input int n, input int frame_pct);
		logic [2:0] mode;
		logic [7:0] count;
		int         pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < frame_pct) begin
				mode = MODE_FRAME;
			end else if (pick < frame_pct + 45) begin
				mode = button_modes[$urandom_range(0, 3)];
			end else if (pick < 96) begin
				mode = MODE_ADD_EDGES;
			end else if (pick < 98) begin
				mode = MODE_CLEAR;
			end else begin
				mode = MODE_UNUSED;
			end
			// Small counts keep the contribution below saturation for
			// small boosts; the extremes still come up often.
			case ($urandom_range(0, 3))
				0: count = 8'($urandom_range(0, 3));
				1: count = 8'($urandom_range(0, 40));
				2: count = 8'($urandom_range(0, 255));
				default: count = EDGE_MAX;
			endcase
			send_command(mode, count, 1'($urandom), 1'($urandom));
		end
	endtask

	// Reset values: empty ring, no edges, strip flag clear, boost of one.
	task automatic test_power_up_state();
		send_command(MODE_FRAME, 8'd0, 1'b1, 1'b1);
		send_command(MODE_FRAME, 8'd1, 1'b0, 1'b0);
		send_command(MODE_UNUSED, EDGE_MAX, 1'b1, 1'b0);
	endtask

	// Presses and releases are queued in order and come out one per frame;
	// a redundant press is ignored.
	task automatic test_button_events();
		send_command(MODE_PWR_PRESS, 8'd0, 1'b0, 1'b0);
		send_command(MODE_PWR_PRESS, 8'd0, 1'b0, 1'b0);
		send_command(MODE_RST_PRESS, 8'd0, 1'b0, 1'b0);
		send_command(MODE_PWR_REL, 8'd0, 1'b0, 1'b0);
		send_command(MODE_RST_REL, 8'd0, 1'b0, 1'b0);
		send_command(MODE_FRAME, 8'd0, 1'b0, 1'b1);
		send_command(MODE_FRAME, 8'd0, 1'b1, 1'b0);
		send_command(MODE_FRAME, 8'd0, 1'b1, 1'b1);
		send_command(MODE_FRAME, 8'd0, 1'b0, 1'b0);
	endtask

	// Edge count saturation, contribution saturation, and clear.
	task automatic test_edge_saturation();
		send_command(MODE_ADD_EDGES, EDGE_MAX, 1'b0, 1'b0);
		send_command(MODE_ADD_EDGES, EDGE_MAX, 1'b0, 1'b0);
		send_command(MODE_ADD_EDGES, 8'd0, 1'b0, 1'b0);
		send_command(MODE_FRAME, EDGE_MAX, 1'b1, 1'b1);
		send_command(MODE_FRAME, 8'd127, 1'b0, 1'b1);
		send_command(MODE_ADD_EDGES, 8'd10, 1'b0, 1'b0);
		send_command(MODE_CLEAR, 8'd0, 1'b0, 1'b0);
		send_command(MODE_FRAME, 8'd0, 1'b0, 1'b0);
	endtask

	// Nine level changes into an eight-entry ring: the last one is dropped.
	// A redundant release is ignored, and clear empties the ring.
	task automatic test_ring_overflow();
		send_command(MODE_PWR_PRESS, 8'd0, 1'b0, 1'b0);
		send_command(MODE_PWR_REL, 8'd0, 1'b0, 1'b0);
		send_command(MODE_PWR_PRESS, 8'd0, 1'b0, 1'b0);
		send_command(MODE_PWR_REL, 8'd0, 1'b0, 1'b0);
		send_command(MODE_RST_PRESS, 8'd0, 1'b0, 1'b0);
		send_command(MODE_RST_REL, 8'd0, 1'b0, 1'b0);
		send_command(MODE_RST_PRESS, 8'd0, 1'b0, 1'b0);
		send_command(MODE_RST_REL, 8'd0, 1'b0, 1'b0);
		send_command(MODE_PWR_PRESS, 8'd0, 1'b0, 1'b0);
		send_command(MODE_RST_REL, 8'd0, 1'b0, 1'b0);
		send_command(MODE_FRAME, 8'd0, 1'b1, 1'b0);
		send_command(MODE_FRAME, 8'd0, 1'b0, 1'b1);
		send_command(MODE_CLEAR, 8'd0, 1'b0, 1'b0);
		send_command(MODE_FRAME, 8'd0, 1'b0, 1'b0);
	endtask

	// Random traffic under several register settings, the extremes among
	// them. Each phase starts with the block drained, so the writes land
	// while nothing is in flight. One phase runs without any idling.
	task automatic test_config_sweep();
		logic [7:0] boosts [6] = '{8'd0, 8'd255, 8'd1, 8'd127, 8'd128, 8'd2};
		for (int i = 0; i < 6; i++) begin
			wait_for_results();
			write_register(REG_STRIP_POWER, {7'd0, i[0]});
			write_register(REG_EDGE_BOOST, boosts[i]);
			tx_idle_on = (i != 2);
			rx_idle_on = (i != 2);
			send_random_commands(60, 10 + 6 * i);
		end
	endtask

	// The result side holds off for a long stretch while commands keep
	// coming, so the block fills up and stalls its command input.
	task automatic test_receiver_holdoff();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		rx_hold_request = 120;
		send_random_commands(40, 30);
	endtask

	// Full-rate streaming with no idling on either side.
	task automatic test_full_rate_stream();
		wait_for_results();
		write_register(REG_STRIP_POWER, 8'd1);
		write_register(REG_EDGE_BOOST, 8'($urandom_range(0, 255)));
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		send_random_commands(110, 25);
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_STRIP_POWER;
		cfg_data = '0;
		clear_transient_state();
		strip_power_cfg = 1'b0;
		edge_boost_cfg = 8'd1;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_power_up_state();
		test_button_events();
		test_edge_saturation();
		test_ring_overflow();
		test_config_sweep();
		test_receiver_holdoff();
		test_full_rate_stream();

		wait_for_results();
		if (mismatch_count == 0) begin
			$display("PASS button_event_frame_builder_unit");
		end else begin
			$display("FAIL button_event_frame_builder_unit");
		end
		$finish;
	end

endmodule
